// ===== rtl/ctc_pkg.sv =====
`default_nettype none

package ctc_pkg;

   // Default geometry of the counter sets
   localparam int NUM_SYMBOLS_DEF = 64;
   localparam int COUNT_BITS_DEF  = 32;

   // Fixed field widths of the transaction ports
   localparam int CODON_BITS = 6;
   localparam int OUT_BITS   = 32;

   // Depth of the command queue and of the result queue
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Operation codes
   typedef enum logic {
      OP_COUNT = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   // Classification of one command, passed from front end to back end
   typedef struct packed {
      logic is_read;
      logic first;
      logic from_ok;
      logic to_ok;
   } op_flags_type;

   localparam int FLAG_BITS = $bits(op_flags_type);

endpackage

`default_nettype wire

// ===== rtl/ctc_ram.sv =====
`default_nettype none

module ctc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ctc_queue.sv =====
`default_nettype none

module ctc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic      [CNT_W-1:0] count
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ctc_front.sv =====
`default_nettype none

module ctc_front #(
   parameter int NUM_SYMBOLS = ctc_pkg::NUM_SYMBOLS_DEF,
   localparam int SYM_W   = $clog2(NUM_SYMBOLS),
   localparam int PAIR_AW = $clog2(NUM_SYMBOLS * NUM_SYMBOLS)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input transaction channel
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic                            req_operation,
   input  wire logic [ctc_pkg::CODON_BITS-1:0]  req_codon,
   input  wire logic                            req_first_of_sequence,
   input  wire logic [ctc_pkg::CODON_BITS-1:0]  req_read_from,
   input  wire logic [ctc_pkg::CODON_BITS-1:0]  req_read_to,
   // Command queue
   input  wire logic                            clearing,
   input  wire logic                            mid_full,
   output logic                                 mid_push,
   output ctc_pkg::op_flags_type                mid_flags,
   output logic      [SYM_W-1:0]                mid_caddr,
   output logic      [PAIR_AW-1:0]              mid_paddr
);

   localparam int EXT_W = SYM_W + ctc_pkg::CODON_BITS;
   localparam int PRD_W = 2 * SYM_W + 1;
   localparam logic [SYM_W:0] NSYM = (SYM_W + 1)'(NUM_SYMBOLS);

   logic [SYM_W-1:0] prev_ff, prev_in;
   logic             accept;
   logic             is_read;
   logic             codon_ok;
   logic             from_ok;
   logic             to_ok;
   logic [EXT_W-1:0] codon_ext;
   logic [EXT_W-1:0] from_ext;
   logic [EXT_W-1:0] to_ext;
   logic [SYM_W-1:0] sym;
   logic [SYM_W-1:0] from_idx;
   logic [SYM_W-1:0] to_idx;
   logic [SYM_W-1:0] row;
   logic [SYM_W-1:0] col;
   logic [PRD_W-1:0] pair_sum;

   assign full   = mid_full || clearing;
   assign accept = push && !full;

   // Classify the transaction and range-check the indices
   always_comb begin
      is_read   = (req_operation == ctc_pkg::OP_READ);
      codon_ok  = (32'(req_codon) < 32'(NUM_SYMBOLS));
      from_ok   = (32'(req_read_from) < 32'(NUM_SYMBOLS));
      to_ok     = (32'(req_read_to) < 32'(NUM_SYMBOLS));
      codon_ext = {{SYM_W{1'b0}}, req_codon};
      from_ext  = {{SYM_W{1'b0}}, req_read_from};
      to_ext    = {{SYM_W{1'b0}}, req_read_to};
      sym       = codon_ext[SYM_W-1:0];
      from_idx  = from_ext[SYM_W-1:0];
      to_idx    = to_ext[SYM_W-1:0];
   end

   // Table addresses: row-major from/to index
   always_comb begin
      row      = is_read ? from_idx : prev_ff;
      col      = is_read ? to_idx : sym;
      pair_sum = PRD_W'(row) * PRD_W'(NSYM) + {{(SYM_W + 1){1'b0}}, col};
   end

   // Command towards the back end; out-of-range counts are dropped here
   always_comb begin
      mid_push          = accept && (is_read || codon_ok);
      mid_flags.is_read = is_read;
      mid_flags.first   = req_first_of_sequence;
      mid_flags.from_ok = from_ok;
      mid_flags.to_ok   = to_ok;
      mid_caddr         = is_read ? from_idx : sym;
      mid_paddr         = pair_sum[PAIR_AW-1:0];
   end

   // Previous codon tracks the last codon actually counted
   always_comb begin
      prev_in = prev_ff;
      if (accept && !is_read && codon_ok) begin
         prev_in = sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ctc_back.sv =====
`default_nettype none

module ctc_back #(
   parameter int NUM_SYMBOLS = ctc_pkg::NUM_SYMBOLS_DEF,
   parameter int COUNT_BITS  = ctc_pkg::COUNT_BITS_DEF,
   localparam int SYM_W      = $clog2(NUM_SYMBOLS),
   localparam int PAIR_DEPTH = NUM_SYMBOLS * NUM_SYMBOLS,
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH),
   localparam int RES_W      = 3 * ctc_pkg::OUT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Command queue head
   input  wire logic                               mid_empty,
   input  wire ctc_pkg::op_flags_type              mid_flags,
   input  wire logic [SYM_W-1:0]                   mid_caddr,
   input  wire logic [PAIR_AW-1:0]                 mid_paddr,
   output logic                                    mid_pop,
   // Result queue
   input  wire logic [ctc_pkg::QUEUE_CNT_BITS-1:0] out_count,
   input  wire logic                               out_full,
   output logic                                    out_push,
   output logic      [RES_W-1:0]                   out_data,
   // Status
   output logic                                    clearing
);

   localparam int CLR_W = PAIR_AW + 1;
   localparam int EXT_W = COUNT_BITS + ctc_pkg::OUT_BITS;
   localparam int QC_W  = ctc_pkg::QUEUE_CNT_BITS;

   // Clearing pass
   logic                  clearing_ff, clearing_in;
   logic [CLR_W-1:0]      clr_cnt_ff, clr_cnt_in;
   // Execute stage
   logic                  b1_valid_ff, b1_valid_in;
   ctc_pkg::op_flags_type b1_flags_ff;
   logic [SYM_W-1:0]      b1_caddr_ff;
   logic [PAIR_AW-1:0]    b1_paddr_ff;
   // Forwarding of the most recent write to each table
   logic                  cfwd_valid_ff, cfwd_valid_in;
   logic [SYM_W-1:0]      cfwd_addr_ff;
   logic [COUNT_BITS-1:0] cfwd_data_ff;
   logic                  pfwd_valid_ff, pfwd_valid_in;
   logic [PAIR_AW-1:0]    pfwd_addr_ff;
   logic [COUNT_BITS-1:0] pfwd_data_ff;
   // Running total
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic                  space_ok;
   logic [COUNT_BITS-1:0] c_rdata;
   logic [COUNT_BITS-1:0] p_rdata;
   logic [COUNT_BITS-1:0] c_cur;
   logic [COUNT_BITS-1:0] p_cur;
   logic [COUNT_BITS-1:0] c_inc;
   logic [COUNT_BITS-1:0] p_inc;
   logic                  do_count;
   logic                  do_pair;
   logic                  c_wr_en;
   logic [SYM_W-1:0]      c_wr_addr;
   logic [COUNT_BITS-1:0] c_wr_data;
   logic                  p_wr_en;
   logic [PAIR_AW-1:0]    p_wr_addr;
   logic [COUNT_BITS-1:0] p_wr_data;
   logic [COUNT_BITS-1:0] cc_val;
   logic [COUNT_BITS-1:0] pc_val;
   logic [EXT_W-1:0]      cc_ext;
   logic [EXT_W-1:0]      pc_ext;
   logic [EXT_W-1:0]      tot_ext;

   assign clearing = clearing_ff;

   // Issue: a read only leaves the queue when its result has a slot reserved
   always_comb begin
      space_ok = (b1_valid_ff && b1_flags_ff.is_read) ?
                 (out_count < QC_W'(ctc_pkg::QUEUE_DEPTH - 1)) : !out_full;
      mid_pop  = !clearing_ff && !mid_empty && (!mid_flags.is_read || space_ok);
      b1_valid_in = mid_pop;
   end

   // Execute: merge forwarded data, saturating increment
   always_comb begin
      c_cur    = (cfwd_valid_ff && (cfwd_addr_ff == b1_caddr_ff)) ? cfwd_data_ff : c_rdata;
      p_cur    = (pfwd_valid_ff && (pfwd_addr_ff == b1_paddr_ff)) ? pfwd_data_ff : p_rdata;
      c_inc    = (&c_cur) ? c_cur : c_cur + COUNT_BITS'(1);
      p_inc    = (&p_cur) ? p_cur : p_cur + COUNT_BITS'(1);
      do_count = b1_valid_ff && !b1_flags_ff.is_read;
      do_pair  = do_count && !b1_flags_ff.first;
      total_in = (do_count && !(&total_ff)) ? total_ff + COUNT_BITS'(1) : total_ff;
   end

   // Write ports: clearing sweep after reset, otherwise the execute stage
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + CLR_W'(1);
         if (clr_cnt_ff == CLR_W'(PAIR_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
      if (clearing_ff) begin
         c_wr_en   = (clr_cnt_ff < CLR_W'(NUM_SYMBOLS));
         c_wr_addr = clr_cnt_ff[SYM_W-1:0];
         c_wr_data = '0;
         p_wr_en   = 1'b1;
         p_wr_addr = clr_cnt_ff[PAIR_AW-1:0];
         p_wr_data = '0;
      end else begin
         c_wr_en   = do_count;
         c_wr_addr = b1_caddr_ff;
         c_wr_data = c_inc;
         p_wr_en   = do_pair;
         p_wr_addr = b1_paddr_ff;
         p_wr_data = p_inc;
      end
      cfwd_valid_in = cfwd_valid_ff || (do_count && !clearing_ff);
      pfwd_valid_in = pfwd_valid_ff || (do_pair && !clearing_ff);
   end

   // Result of a read, low bits of each counter
   always_comb begin
      cc_val   = b1_flags_ff.from_ok ? c_cur : '0;
      pc_val   = (b1_flags_ff.from_ok && b1_flags_ff.to_ok) ? p_cur : '0;
      cc_ext   = {{ctc_pkg::OUT_BITS{1'b0}}, cc_val};
      pc_ext   = {{ctc_pkg::OUT_BITS{1'b0}}, pc_val};
      tot_ext  = {{ctc_pkg::OUT_BITS{1'b0}}, total_ff};
      out_push = b1_valid_ff && b1_flags_ff.is_read;
      out_data = {cc_ext[ctc_pkg::OUT_BITS-1:0], pc_ext[ctc_pkg::OUT_BITS-1:0],
                  tot_ext[ctc_pkg::OUT_BITS-1:0]};
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         b1_valid_ff   <= 1'b0;
         cfwd_valid_ff <= 1'b0;
         pfwd_valid_ff <= 1'b0;
         total_ff      <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clr_cnt_ff    <= clr_cnt_in;
         b1_valid_ff   <= b1_valid_in;
         cfwd_valid_ff <= cfwd_valid_in;
         pfwd_valid_ff <= pfwd_valid_in;
         total_ff      <= total_in;
      end
   end

   // Payload of the execute stage and forwarding registers
   always_ff @(posedge clock) begin
      if (mid_pop) begin
         b1_flags_ff <= mid_flags;
         b1_caddr_ff <= mid_caddr;
         b1_paddr_ff <= mid_paddr;
      end
      if (c_wr_en) begin
         cfwd_addr_ff <= c_wr_addr;
         cfwd_data_ff <= c_wr_data;
      end
      if (p_wr_en) begin
         pfwd_addr_ff <= p_wr_addr;
         pfwd_data_ff <= p_wr_data;
      end
   end

   // Per-codon counts
   ctc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_SYMBOLS)
   ) u_codon_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (mid_pop),
      .rd_addr (mid_caddr),
      .rd_data (c_rdata)
   );

   // Transition counts
   ctc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_en   (mid_pop),
      .rd_addr (mid_paddr),
      .rd_data (p_rdata)
   );

endmodule

`default_nettype wire

// ===== rtl/codon_transition_counter_core.sv =====
// Codon transition counter: per-codon counts, a from/to transition table
// and a running total over a stream of codon indices.
//
// Input channel (push/full): req_operation selects a count or a read
// transaction. A count bumps the codon, the transition from the previous
// counted codon (unless req_first_of_sequence) and the total; it returns
// nothing. Codons beyond the symbol range are dropped. A read returns one
// result with the codon count of req_read_from, the transition count
// req_read_from -> req_read_to and the total.
// Result channel (empty/pop): queue-like; the oldest result sits on rsp_*
// while empty is low and leaves on pop.
// Throughput: one transaction per cycle while full is low, counts and reads
// mixed freely. The read-modify-write loop on the two counter RAMs uses
// forwarding of the previous write. A read result passes through the
// command queue, the execute stage and the result queue before it is
// visible. When the result side stalls, queued commands back up and full
// rises; counts still drain as long as no read is blocked.
// Reset: counters saturate at their maximum. After reset a clearing pass
// zeroes the tables, with full held high throughout.
`default_nettype none

module codon_transition_counter_core #(
   parameter int NUM_SYMBOLS = ctc_pkg::NUM_SYMBOLS_DEF,
   parameter int COUNT_BITS  = ctc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input transactions
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic                               req_operation,
   input  wire logic [ctc_pkg::CODON_BITS-1:0]     req_codon,
   input  wire logic                               req_first_of_sequence,
   input  wire logic [ctc_pkg::CODON_BITS-1:0]     req_read_from,
   input  wire logic [ctc_pkg::CODON_BITS-1:0]     req_read_to,
   // Result transactions
   output logic                                    empty,
   input  wire logic                               pop,
   output logic      [ctc_pkg::OUT_BITS-1:0]       rsp_codon_count,
   output logic      [ctc_pkg::OUT_BITS-1:0]       rsp_pair_count,
   output logic      [ctc_pkg::OUT_BITS-1:0]       rsp_total_count
);

   localparam int SYM_W   = $clog2(NUM_SYMBOLS);
   localparam int PAIR_AW = $clog2(NUM_SYMBOLS * NUM_SYMBOLS);
   localparam int CMD_W   = ctc_pkg::FLAG_BITS + SYM_W + PAIR_AW;
   localparam int RES_W   = 3 * ctc_pkg::OUT_BITS;
   localparam int OB      = ctc_pkg::OUT_BITS;

   logic                               clearing;
   logic                               mid_push;
   logic                               mid_full;
   logic                               mid_pop;
   logic                               mid_empty;
   logic [ctc_pkg::QUEUE_CNT_BITS-1:0] mid_count;
   ctc_pkg::op_flags_type              fe_flags;
   logic [SYM_W-1:0]                   fe_caddr;
   logic [PAIR_AW-1:0]                 fe_paddr;
   logic [CMD_W-1:0]                   mid_wdata;
   logic [CMD_W-1:0]                   mid_rdata;
   ctc_pkg::op_flags_type              be_flags;
   logic [SYM_W-1:0]                   be_caddr;
   logic [PAIR_AW-1:0]                 be_paddr;
   logic                               out_push;
   logic                               out_full;
   logic [RES_W-1:0]                   out_wdata;
   logic [RES_W-1:0]                   out_rdata;
   logic [ctc_pkg::QUEUE_CNT_BITS-1:0] out_count;

   // Front end: accept and classify
   ctc_front #(
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_operation         (req_operation),
      .req_codon             (req_codon),
      .req_first_of_sequence (req_first_of_sequence),
      .req_read_from         (req_read_from),
      .req_read_to           (req_read_to),
      .clearing              (clearing),
      .mid_full              (mid_full),
      .mid_push              (mid_push),
      .mid_flags             (fe_flags),
      .mid_caddr             (fe_caddr),
      .mid_paddr             (fe_paddr)
   );

   // Command queue between the two halves
   assign mid_wdata = {fe_flags, fe_caddr, fe_paddr};
   assign be_flags  = mid_rdata[CMD_W-1 -: ctc_pkg::FLAG_BITS];
   assign be_caddr  = mid_rdata[PAIR_AW +: SYM_W];
   assign be_paddr  = mid_rdata[PAIR_AW-1:0];

   ctc_queue #(
      .WIDTH (CMD_W),
      .DEPTH (ctc_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // Back end: counter tables and read-out
   ctc_back #(
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_flags (be_flags),
      .mid_caddr (be_caddr),
      .mid_paddr (be_paddr),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata),
      .clearing  (clearing)
   );

   // Result queue towards the receiver
   ctc_queue #(
      .WIDTH (RES_W),
      .DEPTH (ctc_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_rdata),
      .empty     (empty),
      .count     (out_count)
   );

   assign rsp_codon_count = out_rdata[2*OB +: OB];
   assign rsp_pair_count  = out_rdata[OB +: OB];
   assign rsp_total_count = out_rdata[OB-1:0];

   // Checks
   a_full_after_reset: assert property (@(posedge clock) reset |=> full)
      else $error("input side open right after reset");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (full && !mid_pop))
      else $error("transaction taken during clearing pass");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result written into a full result queue");

   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> (!mid_full && (mid_count != ctc_pkg::QUEUE_CNT_BITS'(ctc_pkg::QUEUE_DEPTH))))
      else $error("command written into a full command queue");

endmodule

`default_nettype wire
